>>> hdl/plf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Playfair cipher package
// Shared widths, letter codes, key square types and the square lookup logic.
// ---------------------------------------------------------------------------
package plf_pkg;

  localparam int unsigned LetterW   = 5;
  localparam int unsigned Side      = 5;
  localparam int unsigned PosW      = 3;
  localparam int unsigned RowW      = LetterW * Side;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = RowW;
  localparam int unsigned PairDepthDefault = 4;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [PosW-1:0]    pos_t;

  localparam letter_t LetterI = letter_t'(8);
  localparam letter_t LetterJ = letter_t'(9);
  localparam letter_t LetterX = letter_t'(23);
  localparam letter_t LetterY = letter_t'(24);

  // Register map of the configuration port.
  typedef enum logic [CfgIndexW-1:0] {
    CfgRow0    = 3'd0,
    CfgRow1    = 3'd1,
    CfgRow2    = 3'd2,
    CfgRow3    = 3'd3,
    CfgRow4    = 3'd4,
    CfgDecrypt = 3'd5
  } cfg_index_e;

  // Key square: row, column, letter bits. Column 0 sits in the low bits.
  typedef logic [Side-1:0][Side-1:0][LetterW-1:0] square_t;

  // Plain alphabet without J, row 4 in the top bits.
  localparam square_t SquareReset = {
    25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
  };

  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    last;
  } pair_t;

  typedef struct packed {
    logic found;
    pos_t row;
    pos_t col;
  } loc_t;

  typedef struct packed {
    letter_t oa;
    letter_t ob;
  } cipher_t;

  function automatic letter_t filler_for(letter_t l);
    return (l == LetterX) ? LetterY : LetterX;
  endfunction

  // First occurrence wins: scan from the last cell back to cell 0.
  function automatic loc_t locate(square_t sq, letter_t l);
    loc_t res;
    res = '0;
    for (int r = Side - 1; r >= 0; r--) begin
      for (int c = Side - 1; c >= 0; c--) begin
        if (sq[r][c] == l) begin
          res.found = 1'b1;
          res.row   = pos_t'(r);
          res.col   = pos_t'(c);
        end
      end
    end
    return res;
  endfunction

  function automatic pos_t wrap_add(pos_t p, pos_t step);
    logic [PosW:0] sum;
    sum = {1'b0, p} + {1'b0, step};
    if (sum >= (PosW + 1)'(Side)) begin
      sum = sum - (PosW + 1)'(Side);
    end
    return sum[PosW-1:0];
  endfunction

  function automatic cipher_t cipher_pair(square_t sq, logic dec, letter_t a, letter_t b);
    loc_t    la;
    loc_t    lb;
    pos_t    fwd;
    cipher_t res;
    la  = locate(sq, a);
    lb  = locate(sq, b);
    fwd = dec ? pos_t'(Side - 1) : pos_t'(1);
    if (!la.found || !lb.found) begin
      res.oa = a;
      res.ob = b;
    end else if (la.row == lb.row) begin
      res.oa = sq[la.row][wrap_add(la.col, fwd)];
      res.ob = sq[lb.row][wrap_add(lb.col, fwd)];
    end else if (la.col == lb.col) begin
      res.oa = sq[wrap_add(la.row, fwd)][la.col];
      res.ob = sq[wrap_add(lb.row, fwd)][lb.col];
    end else begin
      res.oa = sq[la.row][lb.col];
      res.ob = sq[lb.row][la.col];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hdl/plf_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Playfair cipher stream interfaces
// Valid/ready channels for plain letters in and ciphered letters out.
// ---------------------------------------------------------------------------
interface plf_in_if;
  logic                         valid;
  logic                         ready;
  logic [plf_pkg::LetterW-1:0]  letter_in;
  logic                         last_in;

  modport source (output valid, output letter_in, output last_in, input ready);
  modport sink   (input valid, input letter_in, input last_in, output ready);
endinterface

interface plf_out_if;
  logic                         valid;
  logic                         ready;
  logic [plf_pkg::LetterW-1:0]  letter_out;
  logic                         last_out;

  modport source (output valid, output letter_out, output last_out, input ready);
  modport sink   (input valid, input letter_out, input last_out, output ready);
endinterface
`default_nettype wire

>>> hdl/playfair_digraph_cipher_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Playfair digraph cipher unit
// Pairs incoming letters, inserts fillers and ciphers each pair through a
// configurable 5x5 key square.
// ---------------------------------------------------------------------------
// Letters enter as indices A=0..Z=25 on in_i, J folded onto I, with last_in
// marking the end of a message. The unit pairs them, holding the first letter
// of each pair; in encrypt mode a doubled letter is split, and in both modes a
// lone final letter is padded, with X (Y when the letter is X). Every formed
// pair goes into a small pair queue, and the cipher stage takes one pair from
// the queue head per load into an output register that hands out its two
// letters one after the other. An input word is accepted in any cycle in
// which the queue has room for two pairs, so letters stream in at one per
// cycle while it has room; the output side moves one letter per cycle while
// out_o is ready, and the next queued pair loads as the second letter leaves.
// The key square rows and the mode are to be written on the configuration
// port only while the unit is idle; the unit itself does not enforce this.
// Writes to an index past the register list are ignored.
// ---------------------------------------------------------------------------
module playfair_digraph_cipher_unit #(
  parameter int unsigned PairDepth = plf_pkg::PairDepthDefault
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [plf_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  wire [plf_pkg::CfgDataW-1:0]    cfg_wdata_i,
  plf_in_if.sink                         in_i,
  plf_out_if.source                      out_o
);
  import plf_pkg::*;

  localparam int unsigned PtrW = (PairDepth > 1) ? $clog2(PairDepth) : 1;
  localparam int unsigned CntW = $clog2(PairDepth + 1);

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [CntW-1:0] cnt_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == ptr_t'(PairDepth - 1)) ? '0 : ptr_t'(p + ptr_t'(1));
  endfunction

  // Configuration registers.
  square_t square_q;
  logic    decrypt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      square_q  <= SquareReset;
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i) inside
        [CfgRow0:CfgRow4]: begin
          square_q[cfg_index_i] <= cfg_wdata_i;
        end
        CfgDecrypt: begin
          decrypt_q <= cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pair former. The held letter waits for its partner; a completed pair, or
  // a filler pair, is pushed into the queue at acceptance.
  letter_t held_q, held_d;
  logic    holding_q, holding_d;
  letter_t in_letter;
  logic    in_acc;
  logic [1:0] push_n;
  pair_t   push0, push1;

  assign in_letter = (in_i.letter_in == LetterJ) ? LetterI : in_i.letter_in;
  assign in_acc    = in_i.valid && in_i.ready;

  always_comb begin
    held_d    = held_q;
    holding_d = holding_q;
    push_n    = 2'd0;
    push0     = '{a: in_letter, b: filler_for(in_letter), last: 1'b1};
    push1     = '{a: in_letter, b: filler_for(in_letter), last: 1'b1};
    if (!holding_q) begin
      if (in_i.last_in) begin
        push_n = 2'd1;
      end else begin
        held_d    = in_letter;
        holding_d = 1'b1;
      end
    end else if (!decrypt_q && held_q == in_letter) begin
      // Doubled letter: the held one is split off with a filler and the new
      // one starts the next pair, or is padded if it ends the message.
      push0 = '{a: held_q, b: filler_for(held_q), last: 1'b0};
      if (in_i.last_in) begin
        push_n    = 2'd2;
        held_d    = '0;
        holding_d = 1'b0;
      end else begin
        push_n = 2'd1;
      end
    end else begin
      push0     = '{a: held_q, b: in_letter, last: in_i.last_in};
      push_n    = 2'd1;
      held_d    = '0;
      holding_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      holding_q <= 1'b0;
    end else if (in_acc) begin
      held_q    <= held_d;
      holding_q <= holding_d;
    end
  end

  // Pair queue. Up to two pushes and one pop in a cycle.
  pair_t fifo_q [PairDepth];
  ptr_t  head_q, tail_q;
  cnt_t  count_q;
  logic  load;
  logic [1:0] push_eff;

  assign in_i.ready = (count_q <= cnt_t'(PairDepth - 2));
  assign push_eff   = in_acc ? push_n : 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_eff != 2'd0) begin
      fifo_q[tail_q] <= push0;
    end
    if (push_eff == 2'd2) begin
      fifo_q[ptr_inc(tail_q)] <= push1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_eff == 2'd1) begin
        tail_q <= ptr_inc(tail_q);
      end else if (push_eff == 2'd2) begin
        tail_q <= ptr_inc(ptr_inc(tail_q));
      end
      if (load) begin
        head_q <= ptr_inc(head_q);
      end
      count_q <= cnt_t'(count_q + cnt_t'(push_eff) - cnt_t'(load));
    end
  end

  // Cipher stage and output register. The register holds both letters of a
  // pair; sel_q picks which one is on the output.
  cipher_t ciph;
  pair_t   head_pair;
  logic    ov_q, sel_q, olast_q;
  letter_t oa_q, ob_q;
  logic    out_acc;

  assign head_pair = fifo_q[head_q];
  assign ciph      = cipher_pair(square_q, decrypt_q, head_pair.a, head_pair.b);
  assign out_acc   = out_o.valid && out_o.ready;
  assign load      = (count_q != '0) && (!ov_q || (out_acc && sel_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      sel_q <= 1'b0;
    end else if (load) begin
      ov_q  <= 1'b1;
      sel_q <= 1'b0;
    end else if (out_acc) begin
      if (sel_q) begin
        ov_q  <= 1'b0;
        sel_q <= 1'b0;
      end else begin
        sel_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      oa_q    <= ciph.oa;
      ob_q    <= ciph.ob;
      olast_q <= head_pair.last;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.letter_out = sel_q ? ob_q : oa_q;
  assign out_o.last_out   = sel_q & olast_q;

endmodule
`default_nettype wire
